@@ src/itp_pkg.sv @@
`default_nettype none

package itp_pkg;

  localparam int MAX_VALUES = 256;
  localparam int IDX_W      = $clog2(MAX_VALUES);
  localparam int N_W        = $clog2(MAX_VALUES + 1);
  localparam int SIZE_W     = 9;
  localparam int RANK_W     = 8;
  localparam int VAL_W      = 9;
  localparam int CMP_W      = (N_W > SIZE_W) ? N_W : SIZE_W;

  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic              hit;
    logic [VAL_W-1:0]  value;
    logic              last;
  } token_t;

endpackage

`default_nettype wire

@@ src/itp_cell.sv @@
`default_nettype none

module itp_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [itp_pkg::IDX_W-1:0]    cell_idx_i,
  input  wire logic [itp_pkg::CMP_W-1:0]    size_i,
  input  wire itp_pkg::token_t              tok_i,
  output      itp_pkg::token_t              tok_o
);

  logic            used_q, used_d;
  itp_pkg::token_t tok_q, tok_d;
  logic            in_range;
  logic            eligible;
  logic            pick;

  assign in_range = itp_pkg::CMP_W'(cell_idx_i) < size_i;
  assign eligible = tok_i.valid && !tok_i.hit && !used_q && in_range;
  assign pick     = eligible && (tok_i.rank == '0);

  always_comb begin
    tok_d = tok_i;
    if (pick) begin
      tok_d.hit   = 1'b1;
      tok_d.value = itp_pkg::VAL_W'({1'b0, cell_idx_i} + 1'b1);
    end else if (eligible) begin
      tok_d.rank = tok_i.rank - 1'b1;
    end
  end

  // the last item of a permutation clears the cell as it passes
  always_comb begin
    used_d = used_q;
    if (tok_i.valid && tok_i.last) begin
      used_d = 1'b0;
    end else if (pick) begin
      used_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      used_q <= used_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

@@ src/inversion_table_to_permutation_core.sv @@
`default_nettype none

// Inversion table decoder. Each count passes through a chain of MAX_VALUES
// one-bit cells, one cell per cycle; cell k holds the used flag of value k+1
// and takes the item when its rank has counted down to zero. A new count is
// taken every cycle (busy never rises). Its result is on the result ports,
// marked by done_o, once the count has left the last cell register, and is
// taken at the next edge. The receiver cannot stall: results come in input
// order, one cycle each. Write set_size only when no item is in flight.
module inversion_table_to_permutation_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [itp_pkg::RANK_W-1:0]  smaller_count_i,
  input  wire logic                        last_item_i,
  output      logic                        done_o,
  output      logic [itp_pkg::VAL_W-1:0]   picked_value_o,
  output      logic                        found_o,
  output      logic                        last_out_o,
  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [itp_pkg::SIZE_W-1:0]  cfg_set_size_i
);

  localparam logic [itp_pkg::CMP_W-1:0] MaxN = itp_pkg::CMP_W'(itp_pkg::MAX_VALUES);

  logic [itp_pkg::SIZE_W-1:0] set_size_q;
  logic [itp_pkg::CMP_W-1:0]  size_ext;
  logic [itp_pkg::CMP_W-1:0]  n_eff;
  itp_pkg::token_t            chain [itp_pkg::MAX_VALUES+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q <= itp_pkg::SIZE_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      set_size_q <= cfg_set_size_i;
    end
  end

  assign size_ext = itp_pkg::CMP_W'(set_size_q);
  assign n_eff    = (size_ext > MaxN) ? MaxN : size_ext;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = start && !busy;
    chain[0].rank  = smaller_count_i;
    chain[0].last  = last_item_i;
  end

  for (genvar k = 0; k < itp_pkg::MAX_VALUES; k++) begin : g_cell
    itp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (itp_pkg::IDX_W'(k)),
      .size_i     (n_eff),
      .tok_i      (chain[k]),
      .tok_o      (chain[k+1])
    );
  end

  assign done_o         = chain[itp_pkg::MAX_VALUES].valid;
  assign found_o        = chain[itp_pkg::MAX_VALUES].hit;
  assign picked_value_o = chain[itp_pkg::MAX_VALUES].hit ?
                          chain[itp_pkg::MAX_VALUES].value : '0;
  assign last_out_o     = chain[itp_pkg::MAX_VALUES].last;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
module tb;
  import itp_pkg::*;

  localparam int LATENCY     = MAX_VALUES;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 235;
  localparam int RAND_PHASES = 8;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last;
  } count_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             hit;
    logic             last;
  } pick_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [RANK_W-1:0]   smaller_count_i = '0;
  logic                last_item_i = 1'b0;
  logic                done_o;
  logic [VAL_W-1:0]    picked_value_o;
  logic                found_o;
  logic                last_out_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SIZE_W-1:0]   cfg_set_size_i = '0;

  count_t              count_q[$];
  pick_t               pick_q[$];
  logic [SIZE_W-1:0]   size_reg = SIZE_W'(MAX_VALUES);
  logic [MAX_VALUES-1:0] used_map = '0;
  int                  idle_pct = 0;
  bit                  burst = 1'b0;
  bit                  drv_gap;
  count_t              drv_item;
  int                  fail_cnt = 0;
  int                  quiet_cycles = 0;
  int                  item_cnt;

  inversion_table_to_permutation_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .smaller_count_i(smaller_count_i),
    .last_item_i    (last_item_i),
    .done_o         (done_o),
    .picked_value_o (picked_value_o),
    .found_o        (found_o),
    .last_out_o     (last_out_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_set_size_i (cfg_set_size_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // rank-th free value in 1..n, marks it used; map clears after last
  function automatic pick_t decode_rank(logic [RANK_W-1:0] rank, logic lst);
    pick_t r;
    int    n;
    int    seen;
    int    v;
    n = (int'(size_reg) > MAX_VALUES) ? MAX_VALUES : int'(size_reg);
    r = '0;
    r.last = lst;
    seen = 0;
    for (v = 0; v < n; v++) begin
      if (!r.hit && !used_map[v]) begin
        if (seen == int'(rank)) begin
          r.value = VAL_W'(v + 1);
          r.hit = 1'b1;
          used_map[v] = 1'b1;
        end
        seen++;
      end
    end
    if (lst) used_map = '0;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      smaller_count_i <= '0;
      last_item_i <= 1'b0;
    end else begin
      if (start && !busy) pick_q.push_back(decode_rank(smaller_count_i, last_item_i));
      if ($urandom_range(0, 49) == 0) burst = !burst;
      drv_gap = (idle_pct != 0) && !burst && ($urandom_range(0, 99) < idle_pct);
      if (!start || !busy) begin
        if (count_q.size() != 0 && !drv_gap) begin
          drv_item = count_q.pop_front();
          start <= 1'b1;
          smaller_count_i <= drv_item.rank;
          last_item_i <= drv_item.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pick_q.size() == 0) begin
        $error("result with nothing expected: value %0d found %0b last %0b",
               picked_value_o, found_o, last_out_o);
        fail_cnt++;
      end else begin
        if (picked_value_o !== pick_q[0].value) begin
          $error("picked_value: expected %0d, got %0d", pick_q[0].value, picked_value_o);
          fail_cnt++;
        end
        if (found_o !== pick_q[0].hit) begin
          $error("found: expected %0b, got %0b", pick_q[0].hit, found_o);
          fail_cnt++;
        end
        if (last_out_o !== pick_q[0].last) begin
          $error("last_out: expected %0b, got %0b", pick_q[0].last, last_out_o);
          fail_cnt++;
        end
        void'(pick_q.pop_front());
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o === 1'b1 || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_count(input int rank, input bit lst);
    count_t c;
    c.rank = RANK_W'(rank);
    c.last = lst;
    count_q.push_back(c);
    item_cnt++;
  endtask

  // wait until every count is transferred and every result has come back
  task automatic settle();
    do @(negedge clk_i);
    while (count_q.size() != 0 || start || pick_q.size() != 0);
  endtask

  task automatic write_size(input int value);
    settle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_set_size_i <= SIZE_W'(value);
    do @(posedge clk_i);
    while (!cfg_ready_o);
    size_reg = SIZE_W'(value);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int n;
    int len;
    int kind;
    int k;
    int pct[3];
    pct[0] = 0;
    pct[1] = 76;
    pct[2] = 31;
    item_cnt = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset size: extreme ranks, too-large rank, clear on last
    push_count(255, 0);
    push_count(0, 0);
    push_count(254, 0);
    push_count(253, 0);
    push_count(128, 1);
    push_count(255, 1);
    // empty set
    write_size(0);
    push_count(0, 0);
    push_count(7, 1);
    // size saturates at the map depth
    write_size(511);
    push_count(255, 0);
    push_count(255, 1);
    write_size(1);
    push_count(0, 0);
    push_count(0, 1);
    // size changed while a permutation is open
    write_size(8);
    push_count(7, 0);
    push_count(0, 0);
    write_size(4);
    push_count(3, 0);
    push_count(2, 0);
    write_size(8);
    push_count(4, 1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1: n = MAX_VALUES;
        2: n = 1;
        5: n = $urandom_range(21, MAX_VALUES - 1);
        default: n = $urandom_range(2, 20);
      endcase
      write_size(n);
      idle_pct = pct[p % 3];
      item_cnt = 0;
      while (item_cnt < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
          for (k = 0; k < n; k++) push_count($urandom_range(0, n - k - 1), k == n - 1);
        end else if (kind == 8) begin
          len = $urandom_range(1, n + 2);
          for (k = 0; k < len; k++)
            push_count($urandom_range(0, 1) ? $urandom_range(0, n - 1) : $urandom_range(0, 255),
                       (k == len - 1) && $urandom_range(0, 1));
        end else begin
          push_count($urandom_range(0, 255), $urandom_range(0, 1));
        end
      end
    end

    settle();
    repeat (LATENCY + 40) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
